[rtl/itra_pkg.sv]
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and the digit-to-character map for the integer to
// radix text converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_CHARS_DEF   = 33;

    localparam int DIGIT_W    = 6;
    localparam int RADIX_W    = 6;
    localparam int LIMIT_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;

    localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN = 7'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RADIX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LIMIT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // "0123456789abcdefghijklmnopqrstuvwxyz"; out-of-range codes map to '0'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10)
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        else if (d < 6'd36)
        begin
            c = CHAR_A + {2'b00, d} - 8'd10;
        end
        else
        begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

[rtl/itra_cell.sv]
// ----------------------------------------------------------------------------
// itra_cell
// One digit cell: takes the quotient bit stream of its lower neighbor MSB
// first, keeps the running remainder (its digit) and hands its own quotient
// bits up the row. Also shifts digits up for MSB-first readout.
// ----------------------------------------------------------------------------
module itra_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itra_pkg::cell_ctrl_t          ctrl,
    input  logic [itra_pkg::RADIX_W-1:0]  radix,
    input  logic                          seed,
    input  logic                          in_vld,
    input  logic                          in_bit,
    input  logic [itra_pkg::DIGIT_W-1:0]  shift_digit,
    input  logic                          shift_sig,
    output logic                          out_vld,
    output logic                          out_bit,
    output logic [itra_pkg::DIGIT_W-1:0]  digit,
    output logic                          sig
);

    logic [itra_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic                         sig_reg, sig_next;
    logic                         vld_reg, vld_next;
    logic                         qbit_reg;
    logic [itra_pkg::DIGIT_W:0]   trial;
    logic [itra_pkg::DIGIT_W:0]   diff;
    logic                         ge;

    // one restoring step: 2*rem + bit stays below 2*radix
    assign trial = {rem_reg, in_bit};
    assign ge    = trial >= {1'b0, radix};
    assign diff  = trial - {1'b0, radix};

    always_comb
    begin
        rem_next = rem_reg;
        sig_next = sig_reg;
        priority if (ctrl.clear)
        begin
            rem_next = '0;
            sig_next = seed;
        end
        else if (ctrl.shift)
        begin
            rem_next = shift_digit;
            sig_next = shift_sig;
        end
        else if (in_vld)
        begin
            rem_next = ge ? diff[itra_pkg::DIGIT_W-1:0] : trial[itra_pkg::DIGIT_W-1:0];
            // a 1 in the incoming quotient means this digit is significant
            sig_next = sig_reg | in_bit;
        end
    end

    assign vld_next = in_vld & ~ctrl.clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sig_reg  <= sig_next;
        qbit_reg <= ge;
    end

    assign out_vld = vld_reg;
    assign out_bit = qbit_reg;
    assign digit   = rem_reg;
    assign sig     = sig_reg;

endmodule

[rtl/int_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_radix_ascii
// Signed integer to ASCII text in a configurable radix (2..36), one character
// per output beat, most significant first, leading '-' for negatives.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  in       | in        | in_valid / in_stall | value (VALUE_WIDTH, signed)
//  out      | out       | out_valid/out_stall | character[8], last, status[2]
//  cfg      | in        | cfg_we              | cfg_index, cfg_data[7]
//
//  One value at a time. Conversion streams the magnitude through the digit
//  cell row, then drops leading zeros off the top cell, checks the length,
//  emits a '-' for a negative value and then one beat per digit. The next
//  value is taken once the block is back in idle after its last beat.
//  Error results come from the error state, entered on accept (bad limit, bad
//  radix) or after the row has drained (too long). Reset is asynchronous,
//  active low; config registers come up at 10 / 10. A stalled output beat
//  holds; the block waits in its emit states.
//
//  Datapath: MAX_CHARS identical cells in a row. The magnitude streams MSB
//  first into cell 0; each cell keeps a remainder mod radix and passes its
//  registered quotient bits to the next cell, so cell j ends holding digit
//  j. Cell 0 is always significant, any other cell when its incoming quotient
//  stream was nonzero; a 1 leaving the top cell means the text needs more cells.
// ----------------------------------------------------------------------------
module int_to_radix_ascii #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_CHARS   = itra_pkg::MAX_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input beats
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    // output beats
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [itra_pkg::CHAR_W-1:0]       character,
    output logic                              last,
    output logic [itra_pkg::STATUS_W-1:0]     status,
    // config writes
    input  logic                              cfg_we,
    input  logic [itra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [itra_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W     = $clog2(VALUE_WIDTH + MAX_CHARS);
    localparam int N_W       = $clog2(MAX_CHARS + 1);
    localparam int LEN_W     = $clog2(MAX_CHARS + 2);
    localparam int CMP_W     = LEN_W + itra_pkg::LIMIT_W;
    localparam int CONV_LAST = VALUE_WIDTH + MAX_CHARS - 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_ALIGN = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_ERR   = 3'd6;

    // control
    logic [2:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [N_W-1:0]                    num_reg, num_next;     // digits left / digit count
    logic                              neg_reg, neg_next;
    logic                              ovf_reg, ovf_next;
    logic [itra_pkg::STATUS_W-1:0]     code_reg, code_next;
    logic [VALUE_WIDTH-1:0]            mag_reg, mag_next;
    logic [itra_pkg::RADIX_W-1:0]      radix_reg;
    logic [itra_pkg::LIMIT_W-1:0]      limit_reg;

    // output stage
    logic                              ov_reg, ov_next;
    logic [itra_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic                              last_reg, last_next;
    logic [itra_pkg::STATUS_W-1:0]     st_reg, st_next;

    // cell row
    itra_pkg::cell_ctrl_t              ctrl;
    logic                              feed_vld;
    logic [itra_pkg::DIGIT_W-1:0]      cell_digit [MAX_CHARS];
    logic                              cell_sig   [MAX_CHARS];
    logic                              cell_vld   [MAX_CHARS];
    logic                              cell_bit   [MAX_CHARS];

    logic                              in_accept;
    logic                              slot_free;
    logic                              radix_bad;
    logic [VALUE_WIDTH-1:0]            value_u;
    logic [LEN_W-1:0]                  text_len;
    logic                              too_long;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign slot_free = ~ov_reg | ~out_stall;
    assign value_u   = $unsigned(value);
    assign radix_bad = (radix_reg < itra_pkg::RADIX_MIN) || (radix_reg > itra_pkg::RADIX_MAX);

    // sign counts toward the text; terminator needs room in max_length
    assign text_len = LEN_W'(num_reg) + LEN_W'(neg_reg);
    assign too_long = (CMP_W'(text_len) >= CMP_W'(limit_reg))
                   || (text_len > LEN_W'(MAX_CHARS));

    // ---------------- digit cell row ----------------
    for (genvar j = 0; j < MAX_CHARS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_first
            itra_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .radix       (radix_reg),
                .seed        (1'b1),          // lowest digit always printed
                .in_vld      (feed_vld),
                .in_bit      (mag_reg[VALUE_WIDTH-1]),
                .shift_digit ('0),
                .shift_sig   (1'b0),
                .out_vld     (cell_vld[j]),
                .out_bit     (cell_bit[j]),
                .digit       (cell_digit[j]),
                .sig         (cell_sig[j])
            );
        end
        else
        begin : g_next
            itra_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .radix       (radix_reg),
                .seed        (1'b0),
                .in_vld      (cell_vld[j-1]),
                .in_bit      (cell_bit[j-1]),
                .shift_digit (cell_digit[j-1]),
                .shift_sig   (cell_sig[j-1]),
                .out_vld     (cell_vld[j]),
                .out_bit     (cell_bit[j]),
                .digit       (cell_digit[j]),
                .sig         (cell_sig[j])
            );
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        code_next  = code_reg;
        mag_next   = mag_reg;
        ov_next    = ov_reg & out_stall;
        char_next  = char_reg;
        last_next  = last_reg;
        st_next    = st_reg;
        ctrl       = '0;
        feed_vld   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ctrl.clear = 1'b1;
                    priority if (limit_reg < itra_pkg::LIMIT_MIN)
                    begin
                        code_next  = itra_pkg::ST_BAD_LIMIT;
                        state_next = S_ERR;
                    end
                    else if (radix_bad)
                    begin
                        code_next  = itra_pkg::ST_BAD_RADIX;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        // unsigned magnitude, so the most negative value works
                        neg_next   = value_u[VALUE_WIDTH-1];
                        mag_next   = value_u[VALUE_WIDTH-1]
                                   ? (~value_u + VALUE_WIDTH'(1)) : value_u;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        num_next   = N_W'(MAX_CHARS);
                        state_next = S_CONV;
                    end
                end
            end

            S_CONV:
            begin
                feed_vld = (cnt_reg < CNT_W'(VALUE_WIDTH));
                mag_next = mag_reg << 1;
                ovf_next = ovf_reg | (cell_vld[MAX_CHARS-1] & cell_bit[MAX_CHARS-1]);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CONV_LAST))
                begin
                    state_next = S_ALIGN;
                end
            end

            S_ALIGN:
            begin
                priority if (ovf_reg)
                begin
                    code_next  = itra_pkg::ST_TOO_LONG;
                    state_next = S_ERR;
                end
                else if (cell_sig[MAX_CHARS-1])
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    // drop a leading zero off the top
                    ctrl.shift = 1'b1;
                    num_next   = num_reg - N_W'(1);
                end
            end

            S_CHECK:
            begin
                priority if (too_long)
                begin
                    code_next  = itra_pkg::ST_TOO_LONG;
                    state_next = S_ERR;
                end
                else if (neg_reg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_SIGN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = itra_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    st_next    = itra_pkg::ST_OK;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = itra_pkg::digit_char(cell_digit[MAX_CHARS-1]);
                    last_next  = (num_reg == N_W'(1));
                    st_next    = itra_pkg::ST_OK;
                    ctrl.shift = 1'b1;
                    num_next   = num_reg - N_W'(1);
                    if (num_reg == N_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = itra_pkg::CHAR_NUL;
                    last_next  = 1'b1;
                    st_next    = code_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            code_reg  <= itra_pkg::ST_OK;
            ov_reg    <= 1'b0;
            radix_reg <= itra_pkg::RADIX_RST;
            limit_reg <= itra_pkg::LIMIT_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            num_reg   <= num_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            code_reg  <= code_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    itra_pkg::CFG_RADIX:
                    begin
                        radix_reg <= cfg_data[itra_pkg::RADIX_W-1:0];
                    end
                    itra_pkg::CFG_MAX_LENGTH:
                    begin
                        limit_reg <= cfg_data[itra_pkg::LIMIT_W-1:0];
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        st_reg   <= st_next;
    end

    assign out_valid = ov_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign status    = st_reg;

`ifndef ASSERT_OFF
    // an accepted value either starts the cell row or goes straight to an error
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CONV || state_reg == S_ERR))
        else $error("accepted value did not start conversion or error");

    // every emitted digit comes off a significant top cell
    a_emit_significant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (cell_sig[MAX_CHARS-1] && num_reg != '0))
        else $error("emitting a leading zero or past the digit count");

    // error beats are single, terminal and carry no character
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != itra_pkg::ST_OK) |-> (last && character == itra_pkg::CHAR_NUL))
        else $error("malformed error beat");

    // the cell row is never shifted while bits are still streaming through it
    a_no_shift_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> !ctrl.shift && !ctrl.clear)
        else $error("cell row disturbed during conversion");
`endif

endmodule
